>>> src/fss_pkg.sv
package fss_pkg;

    // field widths
    localparam int RGB_W   = 24;
    localparam int POS_W   = 6;
    localparam int IMG_W   = 8;
    localparam int CH_W    = 8;

    // window shape
    localparam int NUM_NB  = 8;
    localparam int NUM_CH  = 3;

    // sum of eight channel differences, mean over eight neighbours
    localparam int SUM_W     = 11;
    localparam int AVG_SHIFT = 3;

    // sum of three channel means and the final divide by three
    localparam int TOTAL_W    = 10;
    localparam int SHARP_W    = 8;
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = 20;

    typedef logic [RGB_W-1:0]   t_rgb;
    typedef logic [SHARP_W-1:0] t_sharp;

    // one result word
    typedef struct packed {
        logic               taken;
        t_sharp             sharpness;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        t_rgb               rgb;
        logic [IMG_W-1:0]   image;
    } t_result;

    // absolute difference of two channel values
    function automatic logic [CH_W-1:0] abs_diff8(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // floor(x / 3) for x below 768, by reciprocal multiply
    function automatic t_sharp div3(input logic [TOTAL_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(DIV3_MUL);
        return p[DIV3_SHIFT +: SHARP_W];
    endfunction

endpackage

>>> src/fss_ram.sv
module fss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port that holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/fss_sharp.sv
module fss_sharp (
    input  logic            i_clk,
    input  logic            i_en,
    input  fss_pkg::t_rgb   i_centre,
    input  fss_pkg::t_rgb   i_nb [fss_pkg::NUM_NB],
    output fss_pkg::t_sharp o_sharp
);

    logic [fss_pkg::SUM_W-1:0] w_sum    [fss_pkg::NUM_CH];
    logic [fss_pkg::CH_W-1:0]  r_ch_avg [fss_pkg::NUM_CH];
    logic [fss_pkg::TOTAL_W-1:0] w_total;
    fss_pkg::t_sharp           r_sharp;

    // per channel: sum of absolute differences to the eight neighbours
    always_comb begin
        for (int ch = 0; ch < fss_pkg::NUM_CH; ch++) begin
            w_sum[ch] = '0;
            for (int k = 0; k < fss_pkg::NUM_NB; k++) begin
                w_sum[ch] = w_sum[ch] + fss_pkg::SUM_W'(fss_pkg::abs_diff8(
                    i_centre[ch*fss_pkg::CH_W +: fss_pkg::CH_W],
                    i_nb[k][ch*fss_pkg::CH_W +: fss_pkg::CH_W]));
            end
        end
    end

    // first stage: channel means, floor of sum over eight
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < fss_pkg::NUM_CH; ch++) begin
                r_ch_avg[ch] <= w_sum[ch][fss_pkg::SUM_W-1:fss_pkg::AVG_SHIFT];
            end
        end
    end

    // total of the three means
    assign w_total = fss_pkg::TOTAL_W'(r_ch_avg[0]) + fss_pkg::TOTAL_W'(r_ch_avg[1])
                   + fss_pkg::TOTAL_W'(r_ch_avg[2]);

    // second stage: divide by three
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sharp <= fss_pkg::div3(w_total);
        end
    end

    assign o_sharp = r_sharp;

endmodule

>>> src/fss_out.sv
module fss_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fss_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output fss_pkg::t_result o_res,
    output logic             o_full
);

    logic             r_out_vld;
    logic             r_skid_vld;
    fss_pkg::t_result r_out;
    fss_pkg::t_result r_skid;
    logic             w_load;

    // output register free or its word taken this cycle
    assign w_load = !r_out_vld || !i_stall;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld  <= r_skid_vld || i_push;
            r_skid_vld <= 1'b0;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= r_skid_vld ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;
    assign o_full  = r_skid_vld;

endmodule

>>> src/focus_stack_sharpness_select.sv
// channel   direction  handshake            word
// -------   ---------  -------------------  ----------------------------------------
// window    in         i_valid / o_stall    row, col, image id, centre, 8 neighbours
// result    out        o_valid / i_stall    taken, sharpness, row, col, rgb, image
//
// one window per clock while o_stall is low; an accepted window passes stages 1, 2, 3
// and the output register before its result's valid rises; rate is set by the single
// read port and single write port of the best-sharpness memory: read one stage ahead
// of the compare, written back as the word leaves stage 3, forwarded on a hit
// after reset a clearing pass writes ROWS*COLS entries (4096 by default), one per
// cycle, with o_stall high the whole time
// o_stall also rises while the skid register holds a word behind a stalled output
module focus_stack_sharpness_select #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic [7:0]  i_image_id,
    input  logic [23:0] i_centre_rgb,
    input  logic [23:0] i_nb_up_left,
    input  logic [23:0] i_nb_up,
    input  logic [23:0] i_nb_up_right,
    input  logic [23:0] i_nb_left,
    input  logic [23:0] i_nb_right,
    input  logic [23:0] i_nb_down_left,
    input  logic [23:0] i_nb_down,
    input  logic [23:0] i_nb_down_right,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_taken,
    output logic [7:0]  o_sharpness,
    output logic [5:0]  o_out_row,
    output logic [5:0]  o_out_col,
    output logic [23:0] o_chosen_rgb,
    output logic [7:0]  o_chosen_image
);

    localparam int DEPTH = ROWS * COLS;
    localparam int IDX_W = $clog2(DEPTH);

    localparam int POS_W = fss_pkg::POS_W;
    localparam int IMG_W = fss_pkg::IMG_W;

    // handshake and pipeline enable
    logic w_acc;
    logic w_en;
    logic w_full;

    // clearing pass
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_idx;

    // pipeline stages
    logic             r_s1_vld, r_s2_vld, r_s3_vld;
    logic [POS_W-1:0] r_s1_row, r_s2_row, r_s3_row;
    logic [POS_W-1:0] r_s1_col, r_s2_col, r_s3_col;
    logic [IMG_W-1:0] r_s1_img, r_s2_img, r_s3_img;
    fss_pkg::t_rgb    r_s1_ctr, r_s2_ctr, r_s3_ctr;
    fss_pkg::t_rgb    r_s1_nb [fss_pkg::NUM_NB];
    fss_pkg::t_rgb    w_in_nb [fss_pkg::NUM_NB];
    logic [IDX_W-1:0] r_s3_idx;
    logic             r_s3_inr;
    logic [IDX_W-1:0] w_s2_idx;
    logic             w_s2_inr;
    fss_pkg::t_sharp  w_s3_sharp;

    // memory ports and forwarding
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    fss_pkg::t_sharp  w_wdata;
    fss_pkg::t_sharp  w_rdata;
    logic             w_s3_wr;
    logic             r_fwd_hit;
    fss_pkg::t_sharp  r_fwd_data;
    fss_pkg::t_sharp  w_best;
    logic             w_take;

    fss_pkg::t_result w_res;
    fss_pkg::t_result w_out_res;

    assign w_en    = !w_full;
    assign o_stall = r_clr_busy || w_full;
    assign w_acc   = i_valid && !o_stall;

    // neighbours in window order
    assign w_in_nb[0] = i_nb_up_left;
    assign w_in_nb[1] = i_nb_up;
    assign w_in_nb[2] = i_nb_up_right;
    assign w_in_nb[3] = i_nb_left;
    assign w_in_nb[4] = i_nb_right;
    assign w_in_nb[5] = i_nb_down_left;
    assign w_in_nb[6] = i_nb_down;
    assign w_in_nb[7] = i_nb_down_right;

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= w_acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // pixel address and range check, from stage 2
    assign w_s2_idx = IDX_W'(r_s2_row) * IDX_W'(COLS) + IDX_W'(r_s2_col);
    assign w_s2_inr = (32'(r_s2_row) < 32'(ROWS)) && (32'(r_s2_col) < 32'(COLS));

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_row <= i_row;
            r_s1_col <= i_col;
            r_s1_img <= i_image_id;
            r_s1_ctr <= i_centre_rgb;
            for (int k = 0; k < fss_pkg::NUM_NB; k++) begin
                r_s1_nb[k] <= w_in_nb[k];
            end
            r_s2_row <= r_s1_row;
            r_s2_col <= r_s1_col;
            r_s2_img <= r_s1_img;
            r_s2_ctr <= r_s1_ctr;
            r_s3_row <= r_s2_row;
            r_s3_col <= r_s2_col;
            r_s3_img <= r_s2_img;
            r_s3_ctr <= r_s2_ctr;
            r_s3_idx <= w_s2_idx;
            r_s3_inr <= w_s2_inr;
        end
    end

    // sharpness, two stages, lined up with stage 3
    fss_sharp u_sharp (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_centre (r_s1_ctr),
        .i_nb     (r_s1_nb),
        .o_sharp  (w_s3_sharp)
    );

    // compare against stored best, forwarded when the previous word wrote it
    assign w_best  = r_fwd_hit ? r_fwd_data : w_rdata;
    assign w_take  = r_s3_inr && (w_s3_sharp > w_best);
    assign w_s3_wr = w_en && r_s3_vld && w_take;

    // read issued as a word moves into stage 3; catch a write to the same entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (w_en) begin
            r_fwd_hit <= w_s3_wr && (r_s3_idx == w_s2_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fwd_data <= w_s3_sharp;
        end
    end

    // write port shared by clearing pass and update
    assign w_we    = r_clr_busy || w_s3_wr;
    assign w_waddr = r_clr_busy ? r_clr_idx : r_s3_idx;
    assign w_wdata = r_clr_busy ? '0 : w_s3_sharp;

    fss_ram #(
        .WIDTH (fss_pkg::SHARP_W),
        .DEPTH (DEPTH)
    ) u_best (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_en),
        .i_raddr (w_s2_idx),
        .o_rdata (w_rdata)
    );

    // result word
    always_comb begin
        w_res.taken     = w_take;
        w_res.sharpness = w_s3_sharp;
        w_res.row       = r_s3_row;
        w_res.col       = r_s3_col;
        w_res.rgb       = w_take ? r_s3_ctr : '0;
        w_res.image     = w_take ? r_s3_img : '0;
    end

    fss_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && r_s3_vld),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (w_out_res),
        .o_full  (w_full)
    );

    assign o_taken        = w_out_res.taken;
    assign o_sharpness    = w_out_res.sharpness;
    assign o_out_row      = w_out_res.row;
    assign o_out_col      = w_out_res.col;
    assign o_chosen_rgb   = w_out_res.rgb;
    assign o_chosen_image = w_out_res.image;

    // pipeline stays empty through the clearing pass
    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_vld && !r_s2_vld && !r_s3_vld))
        else $error("word in pipeline during clearing pass");

    // skid holds a word only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_valid)
        else $error("skid occupied with empty output register");

    // a takeover always carries a nonzero sharpness
    a_take_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_taken) |-> (o_sharpness != '0))
        else $error("takeover with zero sharpness");

    // no takeover leaves colour and image at zero
    a_not_taken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_taken) |-> (o_chosen_rgb == '0 && o_chosen_image == '0))
        else $error("chosen fields set without takeover");

endmodule
